// ===== rtl/bqpi_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bqpi_pkg
// shared types and codes of the byte queue with positional insert: request and
// result payloads, operation and status codes, default sizes
// ----------------------------------------------------------------------------
package bqpi_pkg;

    localparam int CAPACITY_DEF = 256;

    localparam int OP_W     = 3;
    localparam int DATA_W   = 16;
    localparam int POS_W    = 8;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 9;
    localparam int SIZE_W   = 9;
    localparam int ITEMS_W  = 32;

    localparam logic [SIZE_W-1:0] BUF_SIZE_RESET = 9'd256;
    localparam logic [COUNT_W-1:0] COUNT_MAX     = 9'd511;

    localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
    localparam logic [OP_W-1:0] OP_POP    = 3'd1;
    localparam logic [OP_W-1:0] OP_READ   = 3'd2;
    localparam logic [OP_W-1:0] OP_INSERT = 3'd3;
    localparam logic [OP_W-1:0] OP_SET    = 3'd4;

    localparam logic [STATUS_W-1:0] STAT_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic              wide;
        logic [DATA_W-1:0] data;
        logic [POS_W-1:0]  position;
    } req_t;

    typedef struct packed {
        logic [DATA_W-1:0]   value;
        logic [STATUS_W-1:0] status;
        logic                is_empty;
        logic [COUNT_W-1:0]  item_count;
        logic [COUNT_W-1:0]  byte_fill;
    } rsp_t;

endpackage
`default_nettype wire

// ===== rtl/bqpi_mem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bqpi_mem
// byte store of the queue: one write port, one read port with registered data
// ----------------------------------------------------------------------------
module bqpi_mem
    import bqpi_pkg::*;
#(
    parameter int DEPTH = CAPACITY_DEF,
    parameter int AW    = $clog2(CAPACITY_DEF)
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [7:0]    wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [7:0]    rdata
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== rtl/bqpi_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bqpi_ctrl
// request sequencer: range and room checks, byte mover for compaction and
// insert shifts through the ram ports, item access, index bookkeeping
// ----------------------------------------------------------------------------
module bqpi_ctrl
    import bqpi_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int AW       = $clog2(CAPACITY),
    parameter int IW       = AW + 1
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire req_t          req,
    input  wire logic [IW-1:0] used_size,
    output logic               busy,
    output logic               done,
    output rsp_t               rsp,
    output logic               mem_we,
    output logic      [AW-1:0] mem_waddr,
    output logic      [7:0]    mem_wdata,
    output logic      [AW-1:0] mem_raddr,
    input  wire logic [7:0]    mem_rdata
);

    localparam int CW = ((IW > 10) ? IW : 10) + 1;

    typedef enum logic [11:0] {
        S_IDLE    = 12'b0000_0000_0001,
        S_CHECK   = 12'b0000_0000_0010,
        S_MV_RD   = 12'b0000_0000_0100,
        S_MV_WR   = 12'b0000_0000_1000,
        S_RECHECK = 12'b0000_0001_0000,
        S_WR_LO   = 12'b0000_0010_0000,
        S_WR_HI   = 12'b0000_0100_0000,
        S_RD_LO   = 12'b0000_1000_0000,
        S_RD_HI   = 12'b0001_0000_0000,
        S_RD_CAP  = 12'b0010_0000_0000,
        S_UPDATE  = 12'b0100_0000_0000,
        S_FINISH  = 12'b1000_0000_0000
    } state_t;

    localparam logic [IW-1:0] ONE_I = IW'(1);

    state_t               state_reg, state_next;
    logic [OP_W-1:0]      op_reg, op_next;
    logic                 wide_reg, wide_next;
    logic [DATA_W-1:0]    data_reg, data_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [IW-1:0]        head_reg, head_next;
    logic [IW-1:0]        tail_reg, tail_next;
    logic [ITEMS_W-1:0]   items_reg, items_next;
    logic [DATA_W-1:0]    value_reg, value_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic [IW-1:0]        src_reg, src_next;
    logic [IW-1:0]        dst_reg, dst_next;
    logic [IW-1:0]        cnt_reg, cnt_next;
    logic                 down_reg, down_next;
    logic                 shift_reg, shift_next;
    logic [IW-1:0]        addr_reg, addr_next;
    logic                 done_reg, done_next;
    rsp_t                 rsp_reg, rsp_next;

    logic [CW-1:0]        nb_w, fill_w, off_w, head_w, tail_w, size_w, at_w, top_w;
    logic [IW-1:0]        waddr_full, raddr_full;
    logic                 no_room;

    always_comb
    begin
        nb_w    = wide_reg ? CW'(2) : CW'(1);
        head_w  = CW'(head_reg);
        tail_w  = CW'(tail_reg);
        size_w  = CW'(used_size);
        fill_w  = tail_w - head_w;
        off_w   = wide_reg ? CW'({pos_reg, 1'b0}) : CW'(pos_reg);
        at_w    = head_w + off_w;
        top_w   = tail_w - CW'(1) + nb_w;
        no_room = (tail_w + nb_w) > size_w;
    end

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        wide_next   = wide_reg;
        data_next   = data_reg;
        pos_next    = pos_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        items_next  = items_reg;
        value_next  = value_reg;
        status_next = status_reg;
        src_next    = src_reg;
        dst_next    = dst_reg;
        cnt_next    = cnt_reg;
        down_next   = down_reg;
        shift_next  = shift_reg;
        addr_next   = addr_reg;
        done_next   = 1'b0;
        rsp_next    = rsp_reg;
        mem_we      = 1'b0;
        waddr_full  = addr_reg;
        mem_wdata   = data_reg[7:0];
        raddr_full  = addr_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next    = req.op;
                    wide_next  = req.wide;
                    data_next  = req.data;
                    pos_next   = req.position;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                value_next  = '0;
                status_next = STAT_DONE;
                case (op_reg)
                    OP_PUSH, OP_INSERT:
                    begin
                        if (op_reg == OP_INSERT && off_w > fill_w)
                        begin
                            status_next = STAT_RANGE;
                            state_next  = S_FINISH;
                        end
                        else if (no_room && head_reg != '0)
                        begin
                            src_next   = head_reg;
                            dst_next   = '0;
                            cnt_next   = tail_reg - head_reg;
                            down_next  = 1'b0;
                            shift_next = 1'b0;
                            state_next = S_MV_RD;
                        end
                        else
                        begin
                            state_next = S_RECHECK;
                        end
                    end
                    OP_POP:
                    begin
                        if (fill_w < nb_w)
                        begin
                            status_next = STAT_RANGE;
                            state_next  = S_FINISH;
                        end
                        else
                        begin
                            addr_next  = head_reg;
                            state_next = S_RD_LO;
                        end
                    end
                    OP_READ, OP_SET:
                    begin
                        if ((off_w + nb_w) > fill_w)
                        begin
                            status_next = STAT_RANGE;
                            state_next  = S_FINISH;
                        end
                        else
                        begin
                            addr_next  = at_w[IW-1:0];
                            state_next = (op_reg == OP_SET) ? S_WR_LO : S_RD_LO;
                        end
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_MV_RD:
            begin
                raddr_full = src_reg;
                state_next = S_MV_WR;
            end
            S_MV_WR:
            begin
                mem_we     = 1'b1;
                waddr_full = dst_reg;
                mem_wdata  = mem_rdata;
                cnt_next   = cnt_reg - ONE_I;
                src_next   = down_reg ? src_reg - ONE_I : src_reg + ONE_I;
                dst_next   = down_reg ? dst_reg - ONE_I : dst_reg + ONE_I;
                if (cnt_reg == ONE_I)
                begin
                    if (shift_reg)
                    begin
                        state_next = S_WR_LO;
                    end
                    else
                    begin
                        tail_next  = tail_reg - head_reg;
                        head_next  = '0;
                        state_next = S_RECHECK;
                    end
                end
                else
                begin
                    state_next = S_MV_RD;
                end
            end
            S_RECHECK:
            begin
                if (no_room)
                begin
                    status_next = STAT_FULL;
                    state_next  = S_FINISH;
                end
                else if (op_reg == OP_PUSH)
                begin
                    addr_next  = tail_reg;
                    state_next = S_WR_LO;
                end
                else
                begin
                    addr_next = at_w[IW-1:0];
                    cnt_next  = tail_reg - at_w[IW-1:0];
                    if (tail_reg == at_w[IW-1:0])
                    begin
                        state_next = S_WR_LO;
                    end
                    else
                    begin
                        src_next   = tail_reg - ONE_I;
                        dst_next   = top_w[IW-1:0];
                        down_next  = 1'b1;
                        shift_next = 1'b1;
                        state_next = S_MV_RD;
                    end
                end
            end
            S_WR_LO:
            begin
                mem_we     = 1'b1;
                waddr_full = addr_reg;
                mem_wdata  = data_reg[7:0];
                if (wide_reg)
                begin
                    state_next = S_WR_HI;
                end
                else
                begin
                    state_next = (op_reg == OP_SET) ? S_FINISH : S_UPDATE;
                end
            end
            S_WR_HI:
            begin
                mem_we     = 1'b1;
                waddr_full = addr_reg + ONE_I;
                mem_wdata  = data_reg[15:8];
                state_next = (op_reg == OP_SET) ? S_FINISH : S_UPDATE;
            end
            S_RD_LO:
            begin
                raddr_full = addr_reg;
                state_next = S_RD_HI;
            end
            S_RD_HI:
            begin
                value_next = {8'd0, mem_rdata};
                raddr_full = addr_reg + ONE_I;
                if (wide_reg)
                begin
                    state_next = S_RD_CAP;
                end
                else
                begin
                    state_next = (op_reg == OP_POP) ? S_UPDATE : S_FINISH;
                end
            end
            S_RD_CAP:
            begin
                value_next = {mem_rdata, value_reg[7:0]};
                state_next = (op_reg == OP_POP) ? S_UPDATE : S_FINISH;
            end
            S_UPDATE:
            begin
                if (op_reg == OP_POP)
                begin
                    if ((head_w + nb_w) == tail_w)
                    begin
                        head_next  = '0;
                        tail_next  = '0;
                        items_next = '0;
                    end
                    else
                    begin
                        head_next = head_reg + nb_w[IW-1:0];
                        if (items_reg != '0)
                        begin
                            items_next = items_reg - ITEMS_W'(1);
                        end
                    end
                end
                else
                begin
                    tail_next  = tail_reg + nb_w[IW-1:0];
                    items_next = items_reg + ITEMS_W'(1);
                end
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                done_next           = 1'b1;
                rsp_next.value      = value_reg;
                rsp_next.status     = status_reg;
                rsp_next.is_empty   = (fill_w == '0);
                rsp_next.item_count = (items_reg > ITEMS_W'(COUNT_MAX)) ? COUNT_MAX
                                                                        : items_reg[8:0];
                rsp_next.byte_fill  = (fill_w > CW'(COUNT_MAX)) ? COUNT_MAX : fill_w[8:0];
                state_next          = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            items_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            items_reg <= items_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        wide_reg   <= wide_next;
        data_reg   <= data_next;
        pos_reg    <= pos_next;
        value_reg  <= value_next;
        status_reg <= status_next;
        src_reg    <= src_next;
        dst_reg    <= dst_next;
        cnt_reg    <= cnt_next;
        down_reg   <= down_next;
        shift_reg  <= shift_next;
        addr_reg   <= addr_next;
        rsp_reg    <= rsp_next;
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign rsp       = rsp_reg;
    assign mem_waddr = waddr_full[AW-1:0];
    assign mem_raddr = raddr_full[AW-1:0];

`ifndef NO_ASSERTIONS
    a_head_le_tail: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= tail_reg)
        else $error("head index passed tail index");

    a_tail_in_store: assert property (@(posedge clk) disable iff (!rst_n)
        tail_reg <= IW'(CAPACITY))
        else $error("tail index beyond store");

    a_write_in_store: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (waddr_full < IW'(CAPACITY)))
        else $error("store write beyond capacity");

    a_done_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(state_reg) == S_FINISH))
        else $error("result strobe without finished request");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held more than one cycle");
`endif

endmodule
`default_nettype wire

// ===== rtl/byte_queue_with_positional_insert_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// byte_queue_with_positional_insert_unit
// byte queue over a linear store with push, pop, positional read, insert and
// overwrite of one- or two-byte items, and compaction to the store start
// ----------------------------------------------------------------------------
// A request is taken at a clock edge with start high and busy low; busy stays
// high while it runs, and its result appears on rsp for exactly one cycle with
// done high, which the receiver must take as it comes. Busy drops as done
// rises, so the next request can be taken in the done cycle. Each request runs
// from a check state to a finish state: a read through its byte reads, a set
// its byte writes, a pop its reads and an update, a push or an insert a
// recheck, its writes and an update. One refused as full ends after the
// recheck, one refused by the range check or with an unused op code goes from
// the check to the finish. An insert moves each byte behind the insertion
// point up, and a push or insert whose item would pass the configured size
// first compacts the queue to the store start when the head is not at zero;
// both moves run byte by byte through the one read port and the one write
// port of the store. Writes to cfg_wdata take effect at once and are meant
// for idle periods only. The store has no clearing pass after reset.
module byte_queue_with_positional_insert_unit
    import bqpi_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire req_t              req,
    input  wire logic              cfg_we,
    input  wire logic [SIZE_W-1:0] cfg_wdata,
    output logic                   done,
    output rsp_t                   rsp
);

    localparam int AW = $clog2(CAPACITY);
    localparam int IW = AW + 1;
    localparam int SW = (IW > SIZE_W) ? IW : SIZE_W;

    logic [SIZE_W-1:0] buffer_size_reg;
    logic [SW-1:0]     size_ext;
    logic [IW-1:0]     used_size;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [7:0]        mem_wdata;
    logic [AW-1:0]     mem_raddr;
    logic [7:0]        mem_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buffer_size_reg <= BUF_SIZE_RESET;
        end
        else if (cfg_we)
        begin
            buffer_size_reg <= cfg_wdata;
        end
    end

    // clamp to 2..CAPACITY
    always_comb
    begin
        size_ext = SW'(buffer_size_reg);
        if (size_ext < SW'(2))
        begin
            used_size = IW'(2);
        end
        else if (size_ext > SW'(CAPACITY))
        begin
            used_size = IW'(CAPACITY);
        end
        else
        begin
            used_size = size_ext[IW-1:0];
        end
    end

    bqpi_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .IW       (IW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req       (req),
        .used_size (used_size),
        .busy      (busy),
        .done      (done),
        .rsp       (rsp),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    bqpi_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule
`default_nettype wire

// ===== bench/bqpi_queue_checker.sv =====
// ----------------------------------------------------------------------------
// bqpi_queue_checker
// watches the request, result and size-register channels of the byte queue,
// keeps its own copy of the queue bytes, head, tail and item count, works out
// the result of every accepted request and compares it field by field with
// the result that the block returns
// ----------------------------------------------------------------------------
module bqpi_queue_checker
    import bqpi_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  req_t              req,
    input  logic              cfg_we,
    input  logic [SIZE_W-1:0] cfg_wdata,
    input  logic              done,
    input  rsp_t              rsp,
    output int                pending,
    output int                model_fill,
    output int                errors,
    output int                results_seen,
    output int                full_seen,
    output int                range_seen,
    output int                saturated_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [7:0]        queue_bytes [CAPACITY];
    int unsigned       head_at;
    int unsigned       tail_at;
    int unsigned       held_items;
    logic [SIZE_W-1:0] size_reg;
    rsp_t              awaited_results [$];
    int                mistakes;
    int                n_results;
    int                n_full;
    int                n_range;
    int                n_saturated;

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        if (mistakes < 100)
            $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h",
                     $time, what, got, want);
        mistakes++;
    endtask

    task automatic make_room(input int unsigned nb, output bit ok);
        int unsigned lim;
        int unsigned fill;
        lim = (size_reg < 2) ? 2 : ((size_reg > CAPACITY) ? CAPACITY : size_reg);
        fill = tail_at - head_at;
        if (tail_at + nb > lim && head_at > 0) begin
            for (int unsigned k = 0; k < fill; k++)
                queue_bytes[k] = queue_bytes[head_at + k];
            head_at = 0;
            tail_at = fill;
        end
        ok = (tail_at + nb <= lim);
    endtask

    task automatic put_item(input int unsigned at, input int unsigned nb,
                            input logic [DATA_W-1:0] v);
        queue_bytes[at] = v[7:0];
        if (nb == 2)
            queue_bytes[at + 1] = v[15:8];
    endtask

    function automatic logic [DATA_W-1:0] get_item(input int unsigned at,
                                                   input int unsigned nb);
        logic [DATA_W-1:0] v;
        v = {8'h00, queue_bytes[at]};
        if (nb == 2)
            v[15:8] = queue_bytes[at + 1];
        return v;
    endfunction

    task automatic predict_queue_op(input req_t r, output rsp_t want);
        int unsigned       nb;
        int unsigned       off;
        int unsigned       fill;
        int unsigned       at;
        int                k;
        bit                ok;
        logic [DATA_W-1:0] dat;
        logic [DATA_W-1:0] val;
        logic [STATUS_W-1:0] st;
        nb = r.wide ? 2 : 1;
        off = r.position * nb;
        fill = tail_at - head_at;
        dat = r.wide ? r.data : {8'h00, r.data[7:0]};
        val = '0;
        st = STAT_DONE;
        case (r.op)
            OP_PUSH:
            begin
                make_room(nb, ok);
                if (!ok)
                    st = STAT_FULL;
                else
                begin
                    put_item(tail_at, nb, dat);
                    tail_at += nb;
                    held_items++;
                end
            end
            OP_POP:
            begin
                if (fill < nb)
                    st = STAT_RANGE;
                else
                begin
                    val = get_item(head_at, nb);
                    head_at += nb;
                    if (held_items > 0)
                        held_items--;
                    if (head_at == tail_at)
                    begin
                        head_at = 0;
                        tail_at = 0;
                        held_items = 0;
                    end
                end
            end
            OP_READ:
            begin
                if (off + nb > fill)
                    st = STAT_RANGE;
                else
                    val = get_item(head_at + off, nb);
            end
            OP_INSERT:
            begin
                if (off > fill)
                    st = STAT_RANGE;
                else
                begin
                    make_room(nb, ok);
                    if (!ok)
                        st = STAT_FULL;
                    else
                    begin
                        at = head_at + off;
                        for (k = int'(tail_at) - 1; k >= int'(at); k--)
                            queue_bytes[k + nb] = queue_bytes[k];
                        put_item(at, nb, dat);
                        tail_at += nb;
                        held_items++;
                    end
                end
            end
            OP_SET:
            begin
                if (off + nb > fill)
                    st = STAT_RANGE;
                else
                    put_item(head_at + off, nb, dat);
            end
            default:
            begin
            end
        endcase
        fill = tail_at - head_at;
        want.value = val;
        want.status = st;
        want.is_empty = (fill == 0);
        want.item_count = (held_items > COUNT_MAX) ? COUNT_MAX : held_items[COUNT_W-1:0];
        want.byte_fill = (fill > COUNT_MAX) ? COUNT_MAX : fill[COUNT_W-1:0];
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        rsp_t want;
        if (!rst_n)
        begin
            head_at = 0;
            tail_at = 0;
            held_items = 0;
            size_reg = BUF_SIZE_RESET;
            awaited_results.delete();
            mistakes = 0;
            n_results = 0;
            n_full = 0;
            n_range = 0;
            n_saturated = 0;
        end
        else
        begin
            if (done === 1'b1)
            begin
                if (awaited_results.size() == 0)
                    report_mismatch("result with no request waiting", 32'(rsp.value), 0);
                else
                begin
                    want = awaited_results.pop_front();
                    n_results++;
                    if (rsp.value !== want.value)
                        report_mismatch("value", 32'(rsp.value), 32'(want.value));
                    if (rsp.status !== want.status)
                        report_mismatch("status", 32'(rsp.status), 32'(want.status));
                    if (rsp.is_empty !== want.is_empty)
                        report_mismatch("is_empty", 32'(rsp.is_empty), 32'(want.is_empty));
                    if (rsp.item_count !== want.item_count)
                        report_mismatch("item_count", 32'(rsp.item_count),
                                        32'(want.item_count));
                    if (rsp.byte_fill !== want.byte_fill)
                        report_mismatch("byte_fill", 32'(rsp.byte_fill),
                                        32'(want.byte_fill));
                end
            end
            if (cfg_we === 1'b1)
                size_reg = cfg_wdata;
            if (start === 1'b1 && busy === 1'b0)
            begin
                predict_queue_op(req, want);
                awaited_results.push_back(want);
                if (want.status == STAT_FULL)
                    n_full++;
                if (want.status == STAT_RANGE)
                    n_range++;
                if (held_items > COUNT_MAX)
                    n_saturated++;
            end
        end
        pending <= awaited_results.size();
        model_fill <= tail_at - head_at;
        errors <= mistakes;
        results_seen <= n_results;
        full_seen <= n_full;
        range_seen <= n_range;
        saturated_seen <= n_saturated;
    end

endmodule

// ===== bench/byte_queue_with_positional_insert_unit_tb.sv =====
// ----------------------------------------------------------------------------
// byte_queue_with_positional_insert_unit_tb
// drives push, pop, read, insert and set requests of both item widths into
// the byte queue under several buffer sizes and sender idle rates, including
// full and out-of-range cases and an item count that runs ahead of the bytes
// held; the checker beside the block predicts and compares every result
// ----------------------------------------------------------------------------
module byte_queue_with_positional_insert_unit_tb;
    import bqpi_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 20000;
    localparam logic [OP_W-1:0] OP_SPARE_FIRST = OP_SET + 3'd1;
    localparam logic [OP_W-1:0] OP_SPARE_LAST  = '1;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    req_t              req;
    logic              cfg_we;
    logic [SIZE_W-1:0] cfg_wdata;
    logic              done;
    rsp_t              rsp;

    int pending;
    int model_fill;
    int errors;
    int results_seen;
    int full_seen;
    int range_seen;
    int saturated_seen;

    int idle_pct = 0;
    int sent = 0;
    int size_writes = 0;
    int quiet_cycles = 0;

    byte_queue_with_positional_insert_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .done      (done),
        .rsp       (rsp)
    );

    bqpi_queue_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .req            (req),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .done           (done),
        .rsp            (rsp),
        .pending        (pending),
        .model_fill     (model_fill),
        .errors         (errors),
        .results_seen   (results_seen),
        .full_seen      (full_seen),
        .range_seen     (range_seen),
        .saturated_seen (saturated_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic req_t make_req(input logic [OP_W-1:0] op, input logic wide,
                                      input logic [DATA_W-1:0] data,
                                      input logic [POS_W-1:0] pos);
        req_t r;
        r.op = op;
        r.wide = wide;
        r.data = data;
        r.position = pos;
        return r;
    endfunction

    function automatic req_t random_request(input int fill_now, input int push_pct);
        req_t        r;
        int unsigned pick;
        int unsigned lim;
        r.wide = 1'($urandom_range(1, 0));
        r.data = DATA_W'($urandom_range(65535, 0));
        pick = $urandom_range(99, 0);
        if (pick < push_pct)
            r.op = OP_PUSH;
        else
        begin
            pick = $urandom_range(69, 0);
            if (pick < 20)
                r.op = OP_POP;
            else if (pick < 35)
                r.op = OP_READ;
            else if (pick < 50)
                r.op = OP_INSERT;
            else if (pick < 65)
                r.op = OP_SET;
            else
                r.op = OP_W'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
        end
        lim = fill_now / (r.wide ? 2 : 1) + 1;
        if (lim > 255)
            lim = 255;
        if ($urandom_range(9, 0) < 8)
            r.position = POS_W'($urandom_range(lim, 0));
        else
            r.position = POS_W'($urandom_range(255, 0));
        return r;
    endfunction

    task automatic send_req(input req_t r);
        while ($urandom_range(99, 0) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        req <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sent++;
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic set_buffer_size(input logic [SIZE_W-1:0] sz);
        drain_results();
        cfg_we <= 1'b1;
        cfg_wdata <= sz;
        @(posedge clk);
        cfg_we <= 1'b0;
        size_writes++;
    endtask

    task automatic empty_queue();
        drain_results();
        while (model_fill != 0)
        begin
            send_req(make_req(OP_POP, 1'b0, '0, '0));
            drain_results();
        end
    endtask

    initial
    begin
        logic [SIZE_W-1:0] plan_size;
        start = 1'b0;
        req = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed requests at full size
        set_buffer_size(BUF_SIZE_RESET);
        send_req(make_req(OP_POP, 1'b0, 16'h0000, 8'h00));
        send_req(make_req(OP_POP, 1'b1, 16'hFFFF, 8'hFF));
        send_req(make_req(OP_READ, 1'b0, 16'h0000, 8'h00));
        send_req(make_req(OP_SET, 1'b1, 16'h1234, 8'h00));
        send_req(make_req(OP_INSERT, 1'b0, 16'h00AA, 8'h01));
        send_req(make_req(OP_SPARE_FIRST, 1'b1, 16'hFFFF, 8'hFF));
        send_req(make_req(OP_INSERT, 1'b1, 16'hFFFF, 8'h00));
        send_req(make_req(OP_PUSH, 1'b0, 16'hAB00, 8'hFF));
        send_req(make_req(OP_PUSH, 1'b1, 16'h8001, 8'h00));
        send_req(make_req(OP_READ, 1'b1, 16'h0000, 8'h00));
        send_req(make_req(OP_READ, 1'b0, 16'h0000, 8'hFF));
        send_req(make_req(OP_READ, 1'b1, 16'hFFFF, 8'h01));
        send_req(make_req(OP_SET, 1'b0, 16'hFF5A, 8'h04));
        send_req(make_req(OP_SET, 1'b1, 16'h0000, 8'hFF));
        send_req(make_req(OP_INSERT, 1'b0, 16'h0077, 8'h02));
        send_req(make_req(OP_INSERT, 1'b1, 16'h0000, 8'hFF));
        send_req(make_req(OP_INSERT, 1'b0, 16'h0011, 8'h06));
        send_req(make_req(OP_SPARE_LAST, 1'b0, 16'h0000, 8'h00));
        send_req(make_req(OP_POP, 1'b1, 16'h0000, 8'h00));
        send_req(make_req(OP_POP, 1'b0, 16'h0000, 8'h00));

        // smallest size: one byte held, full buffer, last byte popped
        empty_queue();
        set_buffer_size(9'd2);
        send_req(make_req(OP_PUSH, 1'b0, 16'h00C3, 8'h00));
        send_req(make_req(OP_POP, 1'b1, 16'h0000, 8'h00));
        send_req(make_req(OP_PUSH, 1'b0, 16'h003C, 8'h00));
        send_req(make_req(OP_PUSH, 1'b1, 16'h5555, 8'h00));
        send_req(make_req(OP_POP, 1'b0, 16'h0000, 8'h00));
        send_req(make_req(OP_POP, 1'b0, 16'h0000, 8'h00));

        // random requests over a plan of sizes and sender idle rates
        for (int c = 0; c < 11; c++)
        begin
            case (c)
                0: plan_size = 9'd256;
                1: plan_size = 9'd2;
                2: plan_size = 9'd5;
                3: plan_size = 9'd64;
                4: plan_size = 9'd511;
                5: plan_size = 9'd0;
                6: plan_size = 9'd17;
                7: plan_size = 9'd1;
                8: plan_size = 9'd3;
                9: plan_size = SIZE_W'($urandom_range(511, 0));
                default: plan_size = 9'd256;
            endcase
            set_buffer_size(plan_size);
            idle_pct = (c < 4) ? 7 : ((c < 8) ? 63 : 0);
            repeat (40)
            begin
                send_req(random_request(model_fill, (c % 2) ? 55 : 30));
                if ($urandom_range(39, 0) == 0)
                    drain_results();
            end
        end

        // let the item count run ahead of the bytes held
        idle_pct = 0;
        empty_queue();
        set_buffer_size(9'd4);
        repeat (4)
            send_req(make_req(OP_PUSH, 1'b0, DATA_W'($urandom_range(65535, 0)), '0));
        repeat (20)
        begin
            send_req(make_req(OP_POP, 1'b1, DATA_W'($urandom_range(65535, 0)), '0));
            send_req(make_req(OP_PUSH, 1'b0, DATA_W'($urandom_range(65535, 0)), '0));
            send_req(make_req(OP_INSERT, 1'b0, DATA_W'($urandom_range(65535, 0)),
                              POS_W'($urandom_range(4, 0))));
        end
        empty_queue();

        drain_results();
        repeat (8) @(posedge clk);
        $display("covered %0d requests under %0d buffer size settings", sent, size_writes);
        $display("%0d results checked: %0d full, %0d out of range, %0d with count saturated",
                 results_seen, full_seen, range_seen, saturated_seen);
        if (errors == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
